### rtl/htw_pkg.sv
`default_nettype none
package htw_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    localparam logic RES_FIRED   = 1'b0;
    localparam logic RES_REFUSED = 1'b1;

    localparam int CFG_W   = 16;
    localparam int DELAY_W = 32;
    localparam int TICK_W  = 32;
    localparam int ID_W    = 6;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [ID_W-1:0]    timer_id;
        logic [DELAY_W-1:0] delay_ms;
    } in_item_t;

    typedef struct packed {
        logic            event_res;
        logic [ID_W-1:0] expired_id;
        logic            last;
    } out_item_t;

endpackage
`default_nettype wire

### rtl/htw_if.sv
`default_nettype none
interface htw_in_if;
    import htw_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface htw_out_if;
    import htw_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

### rtl/htw_ram.sv
`default_nettype none
module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // read-first on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

### rtl/hierarchical_timer_wheel_unit.sv
`default_nettype none
// channel | dir | payload                          | handshake
// req     | in  | cmd, timer_id, delay_ms          | valid/ready
// rsp     | out | event_res, expired_id, last      | valid/ready
// cfg     | in  | tick_interval_ms                 | cfg_we, no ready
//
// One item at a time. Add: decode, 32-step divider, set, link read, link write;
// a clamped add skips the divider; a refused or zero-delay add only responds.
// Tick: clear the level-0 bucket head, walk its list, emit fired timers and skip
// cancelled ones; a cascade first relinks the due level-1 bucket, then level 2
// if level 1 wraps. After reset all 384 bucket heads (default sizes) are cleared;
// req is not ready meanwhile. A stalled rsp holds the walk.
module hierarchical_timer_wheel_unit #(
    parameter int LEVEL0_WIDTH = 8,
    parameter int LEVEL1_WIDTH = 6,
    parameter int LEVEL2_WIDTH = 6,
    parameter int MAX_TIMERS   = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    htw_in_if.sink                        req,
    htw_out_if.source                     rsp,
    input  wire logic                     cfg_we,
    input  wire logic [htw_pkg::CFG_W-1:0] cfg_wdata
);
    import htw_pkg::*;

    localparam int L0S   = 1 << LEVEL0_WIDTH;
    localparam int L1S   = 1 << LEVEL1_WIDTH;
    localparam int L2S   = 1 << LEVEL2_WIDTH;
    localparam int NB    = L0S + L1S + L2S;
    localparam int BW    = $clog2(NB);
    localparam int TW    = LEVEL0_WIDTH + LEVEL1_WIDTH + LEVEL2_WIDTH;
    localparam int L01W  = LEVEL0_WIDTH + LEVEL1_WIDTH;
    localparam int AW    = $clog2(MAX_TIMERS);
    localparam int IDW   = $clog2(MAX_TIMERS + 1);
    localparam logic [IDW-1:0] NIL = IDW'(MAX_TIMERS);
    localparam logic [BW-1:0]  L1_BASE = BW'(L0S);
    localparam logic [BW-1:0]  L2_BASE = BW'(L0S + L1S);

    typedef enum logic [17:0] {
        ST_CLEAR     = 18'h00001,
        ST_IDLE      = 18'h00002,
        ST_DECODE    = 18'h00004,
        ST_RESULT    = 18'h00008,
        ST_DIV       = 18'h00010,
        ST_ADD_SET   = 18'h00020,
        ST_LINK_RD   = 18'h00040,
        ST_LINK_WR   = 18'h00080,
        ST_CAS_HRD   = 18'h00100,
        ST_CAS_HWR   = 18'h00200,
        ST_CAS_NRD   = 18'h00400,
        ST_CAS_NODE  = 18'h00800,
        ST_FIRE_HRD  = 18'h01000,
        ST_FIRE_HWR  = 18'h02000,
        ST_FIRE_NRD  = 18'h04000,
        ST_FIRE_NODE = 18'h08000,
        ST_FIRE_EMIT = 18'h10000,
        ST_FIRE_END  = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]    interval_reg;
    logic [TICK_W-1:0]   cur_reg;
    logic [MAX_TIMERS-1:0] busy_reg, canc_reg;
    logic [BW-1:0]       clr_reg;
    logic [1:0]          cmd_reg;
    logic [ID_W-1:0]     id_reg;
    logic [DELAY_W-1:0]  q_reg;
    logic [CFG_W-1:0]    rem_reg;
    logic [CFG_W-1:0]    iv_reg;
    logic [4:0]          cnt_reg;
    logic [TICK_W-1:0]   e_reg;
    logic [IDW-1:0]      n_reg, nx_reg, pend_reg;
    logic                pend_v_reg;
    logic [BW-1:0]       b_reg, cb_reg;
    logic                cas_reg, l2_reg;
    logic                res_reg;
    logic                ov_reg;
    out_item_t           out_reg;

    // memory ports
    logic                exp_we, exp_re;
    logic [AW-1:0]       exp_waddr, exp_raddr;
    logic [TICK_W-1:0]   exp_wdata, exp_rdata;
    logic                lnk_we, lnk_re;
    logic [AW-1:0]       lnk_waddr, lnk_raddr;
    logic [IDW-1:0]      lnk_wdata, lnk_rdata;
    logic                bkt_we, bkt_re;
    logic [BW-1:0]       bkt_waddr, bkt_raddr;
    logic [2*IDW-1:0]    bkt_wdata, bkt_rdata;

    htw_ram #(.WIDTH(TICK_W), .DEPTH(MAX_TIMERS)) u_expire (
        .clk(clk), .we(exp_we), .waddr(exp_waddr), .wdata(exp_wdata),
        .re(exp_re), .raddr(exp_raddr), .rdata(exp_rdata)
    );
    htw_ram #(.WIDTH(IDW), .DEPTH(MAX_TIMERS)) u_link (
        .clk(clk), .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
        .re(lnk_re), .raddr(lnk_raddr), .rdata(lnk_rdata)
    );
    htw_ram #(.WIDTH(2*IDW), .DEPTH(NB)) u_bucket (
        .clk(clk), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
        .re(bkt_re), .raddr(bkt_raddr), .rdata(bkt_rdata)
    );

    logic              o_free;
    logic              o_load;
    logic [CFG_W-1:0]  iv;
    logic              id_ok;
    logic [AW-1:0]     id_idx, n_idx;
    logic [TICK_W-1:0] gap;
    logic [BW-1:0]     link_b;
    logic [IDW-1:0]    bkt_head, bkt_tail;
    logic [CFG_W:0]    div_r2;
    logic              div_ge;
    logic              span_over;
    logic              n_live;

    assign o_free    = !ov_reg || rsp.ready;
    assign iv        = (interval_reg == '0) ? CFG_W'(1) : interval_reg;
    assign id_ok     = 32'(id_reg) < MAX_TIMERS;
    assign id_idx    = AW'(id_reg);
    assign n_idx     = n_reg[AW-1:0];
    assign n_live    = n_reg < NIL;
    assign bkt_head  = bkt_rdata[2*IDW-1:IDW];
    assign bkt_tail  = bkt_rdata[IDW-1:0];
    assign gap       = e_reg - cur_reg;
    assign div_r2    = {rem_reg, q_reg[DELAY_W-1]};
    assign div_ge    = div_r2 >= {1'b0, iv_reg};
    assign span_over = {32'b0, q_reg} > (64'(iv_reg) << TW);

    // bucket by distance to expiry
    always_comb
    begin
        if (gap < TICK_W'(L0S))
        begin
            link_b = BW'(e_reg[LEVEL0_WIDTH-1:0]);
        end
        else if (gap < TICK_W'(64'(1) << L01W))
        begin
            link_b = L1_BASE + BW'(e_reg[L01W-1:LEVEL0_WIDTH]);
        end
        else
        begin
            link_b = L2_BASE + BW'(e_reg[TW-1:L01W]);
        end
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = ov_reg;
    assign rsp.item  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        o_load = 1'b0;
        exp_we = 1'b0; exp_waddr = id_idx; exp_wdata = cur_reg + q_reg;
        exp_re = 1'b0; exp_raddr = n_idx;
        lnk_we = 1'b0; lnk_waddr = n_idx; lnk_wdata = NIL;
        lnk_re = 1'b0; lnk_raddr = n_idx;
        bkt_we = 1'b0; bkt_waddr = clr_reg; bkt_wdata = {NIL, NIL};
        bkt_re = 1'b0; bkt_raddr = link_b;
        case (state_reg)
            ST_CLEAR:
            begin
                bkt_we = 1'b1;
                if (clr_reg == BW'(NB - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (!id_ok || busy_reg[id_idx] || q_reg == '0)
                        begin
                            state_next = ST_RESULT;
                        end
                        else if (span_over)
                        begin
                            state_next = ST_ADD_SET;
                        end
                        else
                        begin
                            state_next = ST_DIV;
                        end
                    end
                    CMD_TICK:
                    begin
                        if (cur_reg[LEVEL0_WIDTH-1:0] == '0 && cur_reg != '0)
                        begin
                            state_next = ST_CAS_HRD;
                        end
                        else
                        begin
                            state_next = ST_FIRE_HRD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RESULT:
            begin
                if (o_free)
                begin
                    o_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_ADD_SET;
                end
            end
            ST_ADD_SET:
            begin
                exp_we = 1'b1;
                state_next = ST_LINK_RD;
            end
            ST_LINK_RD:
            begin
                lnk_we = 1'b1;
                bkt_re = 1'b1;
                state_next = ST_LINK_WR;
            end
            ST_LINK_WR:
            begin
                bkt_we    = 1'b1;
                bkt_waddr = b_reg;
                if (bkt_head == NIL)
                begin
                    bkt_wdata = {n_reg, n_reg};
                end
                else
                begin
                    bkt_wdata = {bkt_head, n_reg};
                    lnk_we    = 1'b1;
                    lnk_waddr = bkt_tail[AW-1:0];
                    lnk_wdata = n_reg;
                end
                state_next = cas_reg ? ST_CAS_NRD : ST_IDLE;
            end
            ST_CAS_HRD:
            begin
                bkt_re    = 1'b1;
                bkt_raddr = cb_reg;
                state_next = ST_CAS_HWR;
            end
            ST_CAS_HWR:
            begin
                bkt_we    = 1'b1;
                bkt_waddr = cb_reg;
                state_next = ST_CAS_NRD;
            end
            ST_CAS_NRD:
            begin
                if (n_live)
                begin
                    exp_re = 1'b1;
                    lnk_re = 1'b1;
                    state_next = ST_CAS_NODE;
                end
                else if (l2_reg)
                begin
                    state_next = ST_CAS_HRD;
                end
                else
                begin
                    state_next = ST_FIRE_HRD;
                end
            end
            ST_CAS_NODE:
            begin
                state_next = ST_LINK_RD;
            end
            ST_FIRE_HRD:
            begin
                bkt_re    = 1'b1;
                bkt_raddr = BW'(cur_reg[LEVEL0_WIDTH-1:0]);
                state_next = ST_FIRE_HWR;
            end
            ST_FIRE_HWR:
            begin
                bkt_we    = 1'b1;
                bkt_waddr = BW'(cur_reg[LEVEL0_WIDTH-1:0]);
                state_next = ST_FIRE_NRD;
            end
            ST_FIRE_NRD:
            begin
                if (n_live)
                begin
                    lnk_re = 1'b1;
                    state_next = ST_FIRE_NODE;
                end
                else
                begin
                    state_next = ST_FIRE_END;
                end
            end
            ST_FIRE_NODE:
            begin
                state_next = canc_reg[n_idx] ? ST_FIRE_NRD : ST_FIRE_EMIT;
            end
            ST_FIRE_EMIT:
            begin
                if (!pend_v_reg || o_free)
                begin
                    o_load = pend_v_reg;
                    state_next = ST_FIRE_NRD;
                end
            end
            ST_FIRE_END:
            begin
                if (!pend_v_reg || o_free)
                begin
                    o_load = pend_v_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            interval_reg <= CFG_W'(10);
            cur_reg      <= '0;
            busy_reg     <= '0;
            canc_reg     <= '0;
            clr_reg      <= '0;
            ov_reg       <= 1'b0;
            pend_v_reg   <= 1'b0;
            cas_reg      <= 1'b0;
            l2_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                interval_reg <= cfg_wdata;
            end
            ov_reg <= o_load || (ov_reg && !rsp.ready);
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + BW'(1);
                end
                ST_IDLE:
                begin
                    cmd_reg <= req.item.cmd;
                    id_reg  <= req.item.timer_id;
                    q_reg   <= req.item.delay_ms;
                    iv_reg  <= iv;
                end
                ST_DECODE:
                begin
                    rem_reg <= '0;
                    cnt_reg <= 5'd31;
                    cas_reg <= cmd_reg == CMD_TICK &&
                               cur_reg[LEVEL0_WIDTH-1:0] == '0 && cur_reg != '0;
                    res_reg <= (!id_ok || busy_reg[id_idx]) ? RES_REFUSED : RES_FIRED;
                    if (cmd_reg == CMD_ADD && span_over)
                    begin
                        q_reg <= DELAY_W'(64'(1) << TW);
                    end
                    if (cmd_reg == CMD_CANCEL && id_ok && busy_reg[id_idx])
                    begin
                        canc_reg[id_idx] <= 1'b1;
                    end
                    if (cmd_reg == CMD_TICK)
                    begin
                        l2_reg  <= cur_reg[L01W-1:LEVEL0_WIDTH] == '0;
                        cb_reg  <= L1_BASE + BW'(cur_reg[L01W-1:LEVEL0_WIDTH]);
                    end
                end
                ST_RESULT:
                begin
                    if (o_free)
                    begin
                        out_reg <= '{event_res: res_reg, expired_id: id_reg, last: 1'b1};
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                    rem_reg <= div_ge ? CFG_W'(div_r2 - {1'b0, iv_reg}) : div_r2[CFG_W-1:0];
                    q_reg   <= {q_reg[DELAY_W-2:0], div_ge};
                end
                ST_ADD_SET:
                begin
                    e_reg <= cur_reg + q_reg;
                    busy_reg[id_idx] <= 1'b1;
                    canc_reg[id_idx] <= 1'b0;
                    n_reg <= IDW'(id_reg);
                end
                ST_LINK_RD:
                begin
                    b_reg <= link_b;
                end
                ST_LINK_WR:
                begin
                    n_reg <= nx_reg;
                end
                ST_CAS_HWR:
                begin
                    n_reg <= bkt_head;
                end
                ST_CAS_NRD:
                begin
                    if (!n_live && l2_reg)
                    begin
                        l2_reg <= 1'b0;
                        cb_reg <= L2_BASE + BW'(cur_reg[TW-1:L01W]);
                    end
                    else if (!n_live)
                    begin
                        cas_reg <= 1'b0;
                    end
                end
                ST_CAS_NODE:
                begin
                    nx_reg <= lnk_rdata;
                    e_reg  <= exp_rdata;
                end
                ST_FIRE_HWR:
                begin
                    n_reg <= bkt_head;
                end
                ST_FIRE_NODE:
                begin
                    nx_reg <= lnk_rdata;
                    busy_reg[n_idx] <= 1'b0;
                    canc_reg[n_idx] <= 1'b0;
                    if (canc_reg[n_idx])
                    begin
                        n_reg <= lnk_rdata;
                    end
                end
                ST_FIRE_EMIT:
                begin
                    // hold one fired timer back so the final one can carry last
                    if (!pend_v_reg || o_free)
                    begin
                        if (pend_v_reg)
                        begin
                            out_reg <= '{event_res: RES_FIRED,
                                         expired_id: ID_W'(pend_reg), last: 1'b0};
                        end
                        pend_reg   <= n_reg;
                        pend_v_reg <= 1'b1;
                        n_reg      <= nx_reg;
                    end
                end
                ST_FIRE_END:
                begin
                    if (!pend_v_reg || o_free)
                    begin
                        if (pend_v_reg)
                        begin
                            out_reg <= '{event_res: RES_FIRED,
                                         expired_id: ID_W'(pend_reg), last: 1'b1};
                        end
                        pend_v_reg <= 1'b0;
                        cur_reg    <= cur_reg + TICK_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire
